FILE: hdl/drs_pkg.sv
package drs_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned CylW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW  = 5;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SSTF = 2'd1,
    POL_LOOK = 2'd2,
    POL_RSVD = 2'd3
  } policy_e;

  typedef enum logic {
    REQ_ARRIVE   = 1'b0,
    REQ_COMPLETE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [15:0] req_id;
    logic [31:0] arrival_time;
    logic [15:0] cylinder;
    logic [31:0] block_address;
    logic [15:0] proc_id;
  } rec_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] new_request_id;
    logic [31:0] new_arrival_time;
    logic [15:0] new_cylinder;
    logic [31:0] new_block_address;
    logic [15:0] new_process_id;
    logic [15:0] head_cylinder;
    logic        scan_up;
  } in_t;

  typedef struct packed {
    logic        serving_present;
    logic [15:0] out_request_id;
    logic [31:0] out_arrival_time;
    logic [15:0] out_cylinder;
    logic [31:0] out_block_address;
    logic [15:0] out_process_id;
    logic [4:0]  waiting_count;
    logic        dropped;
  } out_t;

  // key used while a record travels through the scan: class, seek, arrival
  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] seek;
    logic [31:0] arr;
  } key_t;

  typedef struct packed {
    logic shift;
    logic load;
    rec_t load_rec;
  } cell_ctl_t;

endpackage

FILE: hdl/drs_cell.sv
module drs_cell
  import drs_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  rec_t      next_i,
  output rec_t      rec_o
);

  rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.load) begin
      rec_d = ctl_i.load_rec;
    end else if (ctl_i.shift) begin
      rec_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

FILE: hdl/disk_request_scheduler.sv
// Disk request scheduler. One request is in service and up to QUEUE_DEPTH wait
// in a row of cells that rotates one position per cycle during a completion.
// An arrival presents its result beat in the cycle after accept, and the next
// item is taken in the cycle after that beat leaves. A completion with
// requests queued rotates the row once past a single comparator to find the
// pick, then rotates once more while the picked entry is dropped out of the
// row; the result beat follows the second rotation. A completion with an
// empty queue does no rotation and goes straight to its result beat. The
// result beat is held while the output stalls. One item is worked on at a
// time; the policy register is written between items.
module disk_request_scheduler
  import drs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_OUT
  } state_e;

  state_e         state_q;
  logic [1:0]     policy_q;
  logic [IdxW-1:0] count_q, step_q, best_q, compact_cnt_q;
  logic           have_best_q, dropped_q;
  key_t           best_key_q;
  rec_t           best_rec_q;
  in_t            item_q;
  logic           serv_v_q;
  rec_t           serv_q;

  rec_t      rec   [QUEUE_DEPTH];
  cell_ctl_t ctl   [QUEUE_DEPTH];

  // position 0 is the head of the row; a rotate moves each cell toward 0
  // and feeds cell 0 back to the tail (cell count_q-1)
  rec_t      head_rec;
  logic      rotate, pull;
  logic      tail_load;
  rec_t      tail_rec;
  logic [IdxW-1:0] tail_idx;

  assign head_rec = rec[0];

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      always_comb begin
        ctl[g].shift    = rotate && (IdxW'(g) < count_q);
        ctl[g].load     = tail_load && (IdxW'(g) == tail_idx);
        ctl[g].load_rec = tail_rec;
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
        drs_cell u_cell (.clk_i(clk_i), .ctl_i(ctl[g]), .next_i(rec[g]), .rec_o(rec[g]));
      end else begin : g_mid
        drs_cell u_cell (.clk_i(clk_i), .ctl_i(ctl[g]), .next_i(rec[g+1]),
                         .rec_o(rec[g]));
      end
    end
  endgenerate

  key_t cur_key;
  logic [15:0] c, h;
  logic beyond;
  logic better;

  always_comb begin
    c = head_rec.cylinder;
    h = item_q.head_cylinder;
    beyond = item_q.scan_up ? (c > h) : (c < h);
    cur_key.seek = (c >= h) ? (c - h) : (h - c);
    cur_key.arr  = head_rec.arrival_time;
    cur_key.cls  = 2'd0;
    if (policy_q == POL_SSTF) begin
      cur_key.cls = 2'd0;
    end else if (policy_q == POL_LOOK) begin
      cur_key.cls = beyond ? 2'd0 : 2'd1;
    end else begin
      cur_key.seek = '0;
    end
    better = !have_best_q || (cur_key < best_key_q);
  end

  logic accept_in, arrive;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign arrive      = (in_data_i.req_type == REQ_ARRIVE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    rotate    = 1'b0;
    pull      = 1'b0;
    tail_load = 1'b0;
    tail_rec  = head_rec;
    tail_idx  = count_q - IdxW'(1);
    if (state_q == ST_IDLE && accept_in && arrive && serv_v_q && count_q < IdxW'(QUEUE_DEPTH)) begin
      tail_load = 1'b1;
      tail_idx  = count_q;
      tail_rec  = '{in_data_i.new_request_id, in_data_i.new_arrival_time,
                    in_data_i.new_cylinder, in_data_i.new_block_address,
                    in_data_i.new_process_id};
    end else if (state_q == ST_SCAN) begin
      rotate    = 1'b1;
      tail_load = 1'b1;
    end else if (state_q == ST_COMPACT) begin
      rotate = 1'b1;
      pull   = (compact_cnt_q == best_q);
      tail_load = !pull;
      tail_idx  = count_q - IdxW'(1) - (compact_cnt_q > best_q ? IdxW'(1) : IdxW'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      policy_q      <= POL_FCFS;
      count_q       <= '0;
      step_q        <= '0;
      best_q        <= '0;
      compact_cnt_q <= '0;
      have_best_q   <= 1'b0;
      dropped_q     <= 1'b0;
      serv_v_q      <= 1'b0;
      serv_q        <= '0;
      best_key_q    <= '0;
      best_rec_q    <= '0;
      item_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            policy_q <= cfg_data_i;
          end
          if (accept_in) begin
            item_q    <= in_data_i;
            dropped_q <= 1'b0;
            if (arrive) begin
              if (!serv_v_q) begin
                serv_v_q <= 1'b1;
                serv_q   <= '{in_data_i.new_request_id, in_data_i.new_arrival_time,
                              in_data_i.new_cylinder, in_data_i.new_block_address,
                              in_data_i.new_process_id};
              end else if (count_q >= IdxW'(QUEUE_DEPTH)) begin
                dropped_q <= 1'b1;
              end else begin
                count_q <= count_q + IdxW'(1);
              end
              state_q <= ST_OUT;
            end else if (count_q == '0) begin
              serv_v_q <= 1'b0;
              serv_q   <= '0;
              state_q  <= ST_OUT;
            end else begin
              step_q      <= '0;
              have_best_q <= 1'b0;
              state_q     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (better) begin
            have_best_q <= 1'b1;
            best_key_q  <= cur_key;
            best_q      <= step_q;
            best_rec_q  <= head_rec;
          end
          step_q <= step_q + IdxW'(1);
          if (step_q == count_q - IdxW'(1)) begin
            compact_cnt_q <= '0;
            state_q       <= ST_COMPACT;
          end
        end
        ST_COMPACT: begin
          compact_cnt_q <= compact_cnt_q + IdxW'(1);
          if (compact_cnt_q == count_q - IdxW'(1)) begin
            count_q  <= count_q - IdxW'(1);
            serv_v_q <= 1'b1;
            serv_q   <= best_rec_q;
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_data_o.serving_present   = serv_v_q;
    out_data_o.out_request_id    = serv_q.req_id;
    out_data_o.out_arrival_time  = serv_q.arrival_time;
    out_data_o.out_cylinder      = serv_q.cylinder;
    out_data_o.out_block_address = serv_q.block_address;
    out_data_o.out_process_id    = serv_q.proc_id;
    out_data_o.waiting_count     = CntW'(count_q);
    out_data_o.dropped           = dropped_q;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= IdxW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && dropped_q) |-> count_q == IdxW'(QUEUE_DEPTH))
    else $error("drop with room left");
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMPACT |-> best_q < count_q) else $error("pick out of range");
  a_no_pull_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pull |-> state_q == ST_COMPACT) else $error("stray pull");
`endif

endmodule

FILE: test/tb.sv
module tb
  import drs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_data;

  disk_request_scheduler #(.QUEUE_DEPTH(Depth)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i(cfg_data)
  );

  rec_t wait_q[$];
  rec_t serving;
  logic serving_on;
  policy_e cur_policy;
  out_t serving_expected[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned hold_cycles;
  logic [31:0] clock_stamp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] seek_dist(logic [15:0] c, logic [15:0] h);
    return (c >= h) ? c - h : h - c;
  endfunction

  function automatic int choose_next(in_t it, int filt, bit by_seek);
    int best;
    logic [15:0] best_s;
    logic [15:0] s;
    best = -1;
    best_s = '0;
    foreach (wait_q[i]) begin
      s = by_seek ? seek_dist(wait_q[i].cylinder, it.head_cylinder) : 16'd0;
      if (filt == 1 && !(wait_q[i].cylinder > it.head_cylinder)) continue;
      if (filt == 2 && !(wait_q[i].cylinder < it.head_cylinder)) continue;
      if (best < 0 || s < best_s ||
          (s == best_s && wait_q[i].arrival_time < wait_q[best].arrival_time)) begin
        best = i;
        best_s = s;
      end
    end
    return best;
  endfunction

  function automatic out_t schedule_step(in_t it);
    out_t o;
    int sel;
    logic drop;
    drop = 1'b0;
    if (it.req_type == REQ_ARRIVE) begin
      if (!serving_on) begin
        serving_on = 1'b1;
        serving = {it.new_request_id, it.new_arrival_time, it.new_cylinder,
                   it.new_block_address, it.new_process_id};
      end else if (wait_q.size() >= Depth) begin
        drop = 1'b1;
      end else begin
        wait_q.push_back({it.new_request_id, it.new_arrival_time, it.new_cylinder,
                          it.new_block_address, it.new_process_id});
      end
    end else begin
      if (cur_policy == POL_SSTF) begin
        sel = choose_next(it, 0, 1'b1);
      end else if (cur_policy == POL_LOOK) begin
        sel = choose_next(it, it.scan_up ? 1 : 2, 1'b1);
        if (sel < 0) sel = choose_next(it, 0, 1'b1);
      end else begin
        sel = choose_next(it, 0, 1'b0);
      end
      if (sel >= 0) begin
        serving_on = 1'b1;
        serving = wait_q[sel];
        wait_q.delete(sel);
      end else begin
        serving_on = 1'b0;
        serving = '0;
      end
    end
    o.serving_present = serving_on;
    o.out_request_id = serving.req_id;
    o.out_arrival_time = serving.arrival_time;
    o.out_cylinder = serving.cylinder;
    o.out_block_address = serving.block_address;
    o.out_process_id = serving.proc_id;
    o.waiting_count = 5'(wait_q.size());
    o.dropped = drop;
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (serving_expected.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        if (out_data !== serving_expected[0]) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", serving_expected[0], out_data);
        end
        void'(serving_expected.pop_front());
      end
    end
  end

  int unsigned out_gap;
  int unsigned rx_draw;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      out_gap <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= (out_gap > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(in_t it);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    repeat (gap + 1) @(posedge clk_i);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    serving_expected.push_back(schedule_step(it));
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (serving_expected.size() != 0) @(posedge clk_i);
    repeat (2 * Depth + 10) @(posedge clk_i);
  endtask

  task automatic set_policy(policy_e p);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_policy = p;
  endtask

  function automatic in_t make_arrival(logic [15:0] cyl);
    in_t it;
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = bits[129:0];
    it.req_type = REQ_ARRIVE;
    it.new_cylinder = cyl;
    clock_stamp = clock_stamp + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) it.new_arrival_time = $urandom;
    else it.new_arrival_time = clock_stamp;
    return it;
  endfunction

  function automatic in_t make_completion(logic [15:0] head);
    in_t it;
    logic [159:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = bits[129:0];
    it.req_type = REQ_COMPLETE;
    it.head_cylinder = head;
    return it;
  endfunction

  function automatic logic [15:0] rand_cyl();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    in_t it;
    send_request(make_completion(16'd0));
    it = make_arrival(16'hFFFF);
    it.new_request_id = 16'hFFFF;
    it.new_arrival_time = 32'hFFFFFFFF;
    it.new_block_address = 32'hFFFFFFFF;
    it.new_process_id = 16'hFFFF;
    send_request(it);
    it = make_arrival(16'h0000);
    it.new_request_id = '0;
    it.new_arrival_time = '0;
    it.new_block_address = '0;
    it.new_process_id = '0;
    send_request(it);
    for (int i = 0; i < 17; i++) send_request(make_arrival(16'd10 + i[15:0]));
    send_request(make_completion(16'd12));
    send_request(make_completion(16'd12));
    send_request(make_completion(16'hFFFF));
  endtask

  task automatic test_fill_and_hold();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_request(make_arrival(rand_cyl()));
    drain_results();
    for (int i = 0; i < 20; i++) send_request(make_completion(rand_cyl()));
  endtask

  task automatic test_policy_random(int unsigned n);
    in_t it;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < (wait_q.size() < 8 ? 65 : 40))
        it = make_arrival(rand_cyl());
      else
        it = make_completion(rand_cyl());
      if ($urandom_range(0, 4) == 0) it.head_cylinder = rand_cyl();
      send_request(it);
    end
    while (wait_q.size() != 0 || serving_on) send_request(make_completion(rand_cyl()));
  endtask

  task automatic test_ties();
    in_t it;
    for (int i = 0; i < 6; i++) begin
      it = make_arrival(($urandom_range(0, 1) != 0) ? 16'd100 : 16'd110);
      it.new_arrival_time = $urandom_range(0, 2);
      send_request(it);
    end
    for (int i = 0; i < 7; i++) begin
      it = make_completion(16'd105);
      send_request(it);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = POL_FCFS;
    cur_policy = POL_FCFS;
    serving_on = 1'b0;
    serving = '0;
    mismatches = 0;
    cycles = 0;
    hold_cycles = 0;
    clock_stamp = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_hold();
    set_policy(POL_SSTF);
    test_directed();
    test_ties();
    test_policy_random(200);
    set_policy(POL_LOOK);
    test_ties();
    test_policy_random(250);
    set_policy(POL_RSVD);
    test_policy_random(100);
    set_policy(POL_FCFS);
    test_ties();
    test_policy_random(150);
    set_policy(POL_LOOK);
    test_fill_and_hold();
    drain_results();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/drs_pkg.sv
hdl/drs_cell.sv
hdl/disk_request_scheduler.sv
test/tb.sv
